/* rtl/lsfg_pkg.sv */
// Shared constants and types for the LED strip frame generator.
// No dependencies; every other file of the block but lsfg_queue imports this package.
package lsfg_pkg;

   localparam int MAX_LEDS_DEF = 8;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam int LED_COUNT_W = 4;
   localparam int PIX_INDEX_W = 8;
   localparam int COLOR_W = 24;
   localparam int BYTE_W = 8;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_SHOW = 1'b1;

   localparam logic [BYTE_W-1:0] START_BYTE = 8'h00;
   localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hFF;
   localparam logic [BYTE_W-1:0] END_BYTE = 8'hFF;
   localparam logic [1:0] START_LAST = 2'd3;   // four start bytes, counted 0..3

   // Sub-byte positions inside one pixel record
   localparam logic [1:0] SEL_HEADER = 2'd0;
   localparam logic [1:0] SEL_RED = 2'd1;
   localparam logic [1:0] SEL_GREEN = 2'd2;
   localparam logic [1:0] SEL_BLUE = 2'd3;

   typedef struct packed {
      logic show;
      logic [PIX_INDEX_W-1:0] pixel_index;
      logic [COLOR_W-1:0] color;
   } lsfg_cmd_type;

endpackage

/* rtl/lsfg_if.sv */
// Handshake channels of the LED strip frame generator: request and response.
// Depends on lsfg_pkg for the field widths.
interface lsfg_req_if
   import lsfg_pkg::*;
();
   logic valid;
   logic ready;
   logic cmd;
   logic [PIX_INDEX_W-1:0] pixel_index;
   logic [COLOR_W-1:0] color;

   modport source (output valid, output cmd, output pixel_index, output color, input ready);
   modport sink (input valid, input cmd, input pixel_index, input color, output ready);
endinterface

interface lsfg_rsp_if
   import lsfg_pkg::*;
();
   logic valid;
   logic ready;
   logic [BYTE_W-1:0] out_byte;
   logic last_byte;

   modport source (output valid, output out_byte, output last_byte, input ready);
   modport sink (input valid, input out_byte, input last_byte, output ready);
endinterface

/* rtl/led_strip_frame_generator.sv */
// The first frame byte of a show passes from the command queue through the sequencer
// state register into the response register; a write goes from the queue to the pixel store.
// A show frame holds four start bytes, four bytes per LED and one end byte when n is nonzero
// (37 bytes for eight LEDs); the sequencer emits one byte per cycle while the sink is ready.
// Requests are taken every cycle while the two-entry command queue has room.
// Reset (synchronous): LED count to zero, pixel store to black, queue and output empty.
module led_strip_frame_generator
   import lsfg_pkg::*;
#(
   parameter int MAX_LEDS = MAX_LEDS_DEF,
   localparam int CNT_W = $clog2(MAX_LEDS + 1)
) (
   input  logic clock,
   input  logic reset,
   lsfg_req_if.sink req_chan,
   lsfg_rsp_if.source rsp_chan,
   input  logic csr_we,
   input  logic [LED_COUNT_W-1:0] csr_wdata
);

   logic push;
   lsfg_cmd_type push_cmd;
   logic queue_full;
   logic queue_empty;
   logic queue_pop;
   lsfg_cmd_type head_cmd;
   logic [CNT_W-1:0] eff_count;

   lsfg_front #(
      .MAX_LEDS(MAX_LEDS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req(req_chan),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .push(push),
      .push_cmd(push_cmd),
      .queue_full(queue_full),
      .eff_count(eff_count)
   );

   lsfg_queue #(
      .WIDTH($bits(lsfg_cmd_type)),
      .DEPTH(QUEUE_DEPTH_DEF)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data(push_cmd),
      .full(queue_full),
      .pop(queue_pop),
      .pop_data(head_cmd),
      .empty(queue_empty)
   );

   lsfg_back #(
      .MAX_LEDS(MAX_LEDS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cmd(head_cmd),
      .cmd_empty(queue_empty),
      .cmd_pop(queue_pop),
      .eff_count(eff_count),
      .rsp(rsp_chan)
   );

endmodule

/* rtl/lsfg_front.sv */
// Front end: holds the LED count register, accepts requests, drops
// out-of-range writes and pushes the rest into the command queue. Uses lsfg_pkg.
module lsfg_front
   import lsfg_pkg::*;
#(
   parameter int MAX_LEDS = MAX_LEDS_DEF,
   localparam int CNT_W = $clog2(MAX_LEDS + 1)
) (
   input  logic clock,
   input  logic reset,
   lsfg_req_if.sink req,
   input  logic csr_we,
   input  logic [LED_COUNT_W-1:0] csr_wdata,
   output logic push,
   output lsfg_cmd_type push_cmd,
   input  logic queue_full,
   output logic [CNT_W-1:0] eff_count
);

   logic [LED_COUNT_W-1:0] led_count_ff;
   logic [LED_COUNT_W-1:0] led_count_in;
   logic in_range;
   logic is_show;

   always_comb begin
      led_count_in = led_count_ff;
      if (csr_we) begin
         led_count_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_count_ff <= '0;
      end else begin
         led_count_ff <= led_count_in;
      end
   end

   // Clamp the count to the store capacity
   always_comb begin
      if (led_count_ff > LED_COUNT_W'(MAX_LEDS)) begin
         eff_count = CNT_W'(MAX_LEDS);
      end else begin
         eff_count = led_count_ff[CNT_W-1:0];
      end
   end

   assign is_show = (req.cmd == CMD_SHOW);
   assign in_range = (req.pixel_index < PIX_INDEX_W'(eff_count));
   assign req.ready = !queue_full;

   // Drop writes beyond the strand; they take the handshake but no queue slot
   assign push = req.valid && !queue_full && (is_show || in_range);
   assign push_cmd.show = is_show;
   assign push_cmd.pixel_index = req.pixel_index;
   assign push_cmd.color = req.color;

endmodule

/* rtl/lsfg_queue.sv */
// Small register FIFO between the front end and the frame sequencer.
// Generic payload width; no package needed.
module lsfg_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  logic [WIDTH-1:0] push_data,
   output logic full,
   input  logic pop,
   output logic [WIDTH-1:0] pop_data,
   output logic empty
);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic do_push, do_pop;

   assign full = (fill_ff == CNT_W'(DEPTH));
   assign empty = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/lsfg_back.sv */
// Back end: executes queued commands, owns the pixel store and walks the
// byte frame into the response register. Uses lsfg_pkg and lsfg_rsp_if.
module lsfg_back
   import lsfg_pkg::*;
#(
   parameter int MAX_LEDS = MAX_LEDS_DEF,
   localparam int CNT_W = $clog2(MAX_LEDS + 1),
   localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1
) (
   input  logic clock,
   input  logic reset,
   input  lsfg_cmd_type cmd,
   input  logic cmd_empty,
   output logic cmd_pop,
   input  logic [CNT_W-1:0] eff_count,
   lsfg_rsp_if.source rsp
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_START = 2'd1;
   localparam logic [1:0] ST_PIXEL = 2'd2;
   localparam logic [1:0] ST_END = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [1:0] sub_ff, sub_in;
   logic [IDX_W-1:0] pix_ff, pix_in;
   logic [COLOR_W-1:0] store_ff [MAX_LEDS];
   logic [COLOR_W-1:0] pixel;
   logic out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic out_last_ff, out_last_in;
   logic out_load;
   logic store_we;
   logic [CNT_W-1:0] top_pix;

   assign out_load = !out_valid_ff || rsp.ready;
   assign cmd_pop = (state_ff == ST_IDLE) && !cmd_empty;
   assign store_we = cmd_pop && !cmd.show;
   assign pixel = store_ff[pix_ff];
   assign top_pix = eff_count - 1'b1;

   always_comb begin
      state_in = state_ff;
      sub_in = sub_ff;
      pix_in = pix_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_pop && cmd.show) begin
               state_in = ST_START;
               sub_in = '0;
            end
         end
         ST_START: begin
            if (out_load) begin
               out_valid_in = 1'b1;
               out_byte_in = START_BYTE;
               out_last_in = 1'b0;
               sub_in = sub_ff + 1'b1;
               if (sub_ff == START_LAST) begin
                  // Empty strand: the frame ends on the last start byte
                  if (eff_count == '0) begin
                     out_last_in = 1'b1;
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_PIXEL;
                     pix_in = top_pix[IDX_W-1:0];
                  end
               end
            end
         end
         ST_PIXEL: begin
            if (out_load) begin
               out_valid_in = 1'b1;
               out_last_in = 1'b0;
               case (sub_ff)
                  SEL_HEADER: out_byte_in = HEADER_BYTE;
                  SEL_RED: out_byte_in = pixel[23:16];
                  SEL_GREEN: out_byte_in = pixel[15:8];
                  default: out_byte_in = pixel[7:0];
               endcase
               sub_in = sub_ff + 1'b1;
               if (sub_ff == SEL_BLUE) begin
                  if (pix_ff == '0) begin
                     state_in = ST_END;
                  end else begin
                     pix_in = pix_ff - 1'b1;
                  end
               end
            end
         end
         ST_END: begin
            // (n+15)/16 is one for every nonzero count of a 4-bit register
            if (out_load) begin
               out_valid_in = 1'b1;
               out_byte_in = END_BYTE;
               out_last_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
         sub_ff <= '0;
         pix_ff <= '0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
         sub_ff <= sub_in;
         pix_ff <= pix_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_LEDS; i++) begin
            store_ff[i] <= '0;
         end
      end else if (store_we) begin
         store_ff[cmd.pixel_index[IDX_W-1:0]] <= cmd.color;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.out_byte = out_byte_ff;
   assign rsp.last_byte = out_last_ff;

endmodule

/* rtl/lsfg_checker.sv */
// Port-level checks on the LED strip frame generator, bound to the top level.
// Uses lsfg_pkg for byte constants.
module lsfg_checker
   import lsfg_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [BYTE_W-1:0] out_byte,
   input logic last_byte
);

   // Hold the response while the sink stalls
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) && $stable(last_byte))
      else $error("response dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // A frame ends on a start byte (empty strand) or an end byte
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && last_byte |-> out_byte == START_BYTE || out_byte == END_BYTE)
      else $error("last byte is neither a start nor an end byte");

   // A byte that directly follows a finished frame opens a new one
   a_frame_opens: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(rsp_valid && rsp_ready && last_byte)
         |-> out_byte == START_BYTE && !last_byte)
      else $error("frame does not open with a start byte");

endmodule

bind led_strip_frame_generator lsfg_checker u_lsfg_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .out_byte(rsp_chan.out_byte),
   .last_byte(rsp_chan.last_byte)
);

/* test/lsfg_frame_checker.sv */
// Scoreboard for the LED strip frame generator: tracks pixel store and LED count,
// predicts the byte frame of every show item and compares it with the response channel.
// Depends on lsfg_pkg and the lsfg_req_if / lsfg_rsp_if channel interfaces.
module lsfg_frame_checker
   import lsfg_pkg::*;
(
   input  logic clock,
   input  logic reset,
   lsfg_req_if req_mon,
   lsfg_rsp_if rsp_mon,
   input  logic csr_we,
   input  logic [LED_COUNT_W-1:0] csr_wdata,
   output int bytes_pending,
   output int fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int START_COUNT = int'(START_LAST) + 1;
   localparam int END_GROUP = 16;
   localparam int IDX_W = (MAX_LEDS_DEF > 1) ? $clog2(MAX_LEDS_DEF) : 1;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic last;
   } frame_byte_type;

   logic [COLOR_W-1:0] shadow_store [MAX_LEDS_DEF];
   logic [LED_COUNT_W-1:0] shadow_count;
   frame_byte_type expected_bytes [$];

   initial begin
      bytes_pending = 0;
      fail_count = 0;
   end

   // A count above capacity acts as full capacity.
   function automatic int active_leds();
      return (int'(shadow_count) > MAX_LEDS_DEF) ? MAX_LEDS_DEF : int'(shadow_count);
   endfunction

   task automatic queue_frame();
      int n_leds;
      n_leds = active_leds();
      for (int s = 0; s < START_COUNT; s++)
         expected_bytes.push_back('{data: START_BYTE, last: 1'b0});
      // Highest pixel goes out first.
      for (int p = n_leds - 1; p >= 0; p--) begin
         expected_bytes.push_back('{data: HEADER_BYTE, last: 1'b0});
         expected_bytes.push_back('{data: shadow_store[p][23:16], last: 1'b0});
         expected_bytes.push_back('{data: shadow_store[p][15:8], last: 1'b0});
         expected_bytes.push_back('{data: shadow_store[p][7:0], last: 1'b0});
      end
      for (int e = 0; e < (n_leds + END_GROUP - 1) / END_GROUP; e++)
         expected_bytes.push_back('{data: END_BYTE, last: 1'b0});
      expected_bytes[expected_bytes.size() - 1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      frame_byte_type want;
      int errs;
      errs = 0;
      if (reset) begin
         foreach (shadow_store[i]) shadow_store[i] = '0;
         shadow_count = '0;
         expected_bytes.delete();
      end else begin
         if (csr_we) shadow_count = csr_wdata;
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.cmd == CMD_SHOW)
               queue_frame();
            else if (int'(req_mon.pixel_index) < active_leds())
               shadow_store[req_mon.pixel_index[IDX_W-1:0]] = req_mon.color;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected item: out_byte 0x%02h, last_byte %0b",
                      rsp_mon.out_byte, rsp_mon.last_byte);
               errs++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_mon.out_byte !== want.data) begin
                  $error("out_byte: expected 0x%02h, got 0x%02h", want.data, rsp_mon.out_byte);
                  errs++;
               end
               if (rsp_mon.last_byte !== want.last) begin
                  $error("last_byte: expected %0b, got %0b", want.last, rsp_mon.last_byte);
                  errs++;
               end
            end
         end
      end
      bytes_pending <= expected_bytes.size();
      fail_count <= fail_count + errs;
   end

endmodule

/* test/testbench.sv */
// Top of the LED strip frame generator testbench: clock, reset, LED count writes,
// request stimulus, response back-pressure, watchdog and verdict.
// Depends on lsfg_pkg, the channel interfaces, the block and lsfg_frame_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import lsfg_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int TARGET_ITEMS = 210;
   localparam int HOLDOFF = 10;
   localparam int TAIL_CYCLES = 20;
   localparam logic [COLOR_W-1:0] DIRECTED_COLORS [MAX_LEDS_DEF] = '{
      24'hFFFFFF, 24'h000000, 24'hAA55AA, 24'h55AA55,
      24'h123456, 24'h800001, 24'h7FFFFE, 24'hF00F0F
   };

   logic clock;
   logic reset;
   logic csr_we;
   logic [LED_COUNT_W-1:0] csr_wdata;
   logic [LED_COUNT_W-1:0] cur_count;
   int bytes_pending;
   int fail_count;
   int items_sent;
   bit no_gaps;

   lsfg_req_if req_bus ();
   lsfg_rsp_if rsp_bus ();

   led_strip_frame_generator i_dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   lsfg_frame_checker i_checker (
      .clock(clock),
      .reset(reset),
      .req_mon(req_bus),
      .rsp_mon(rsp_bus),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .bytes_pending(bytes_pending),
      .fail_count(fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap();
      int roll;
      if (no_gaps) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [LED_COUNT_W-1:0] pick_count();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) return LED_COUNT_W'(MAX_LEDS_DEF);
      if (roll < 40) return '1;
      if (roll < 50) return '0;
      return LED_COUNT_W'($urandom_range(0, 15));
   endfunction

   function automatic int active_leds();
      return (int'(cur_count) > MAX_LEDS_DEF) ? MAX_LEDS_DEF : int'(cur_count);
   endfunction

   // Hold valid until the item is taken, then idle for a random gap.
   task automatic send_item(input logic show, input logic [PIX_INDEX_W-1:0] idx,
                            input logic [COLOR_W-1:0] col);
      int gap;
      req_bus.valid <= 1'b1;
      req_bus.cmd <= show;
      req_bus.pixel_index <= idx;
      req_bus.color <= col;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_frames_done();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (bytes_pending != 0) @(posedge clock);
   endtask

   // Writes still in the command queue give no response: let them settle first.
   task automatic set_led_count(input logic [LED_COUNT_W-1:0] value);
      wait_frames_done();
      repeat (HOLDOFF) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      cur_count = value;
   endtask

   task automatic run_random_phase(input bit force_pause);
      int n_items;
      int roll;
      set_led_count(pick_count());
      no_gaps = ($urandom_range(0, 3) == 0);
      n_items = $urandom_range(8, 24);
      for (int k = 0; k < n_items; k++) begin
         if (k == n_items / 2 && (force_pause || $urandom_range(0, 2) == 0))
            wait_frames_done();
         roll = $urandom_range(0, 99);
         if (roll < 25)
            send_item(CMD_SHOW, PIX_INDEX_W'($urandom), COLOR_W'($urandom));
         else if (roll < 88 && active_leds() > 0)
            send_item(CMD_WRITE, PIX_INDEX_W'($urandom_range(0, active_leds() - 1)),
                      COLOR_W'($urandom));
         else
            send_item(CMD_WRITE, PIX_INDEX_W'($urandom), COLOR_W'($urandom));
      end
      no_gaps = 1'b0;
   endtask

   // Response back-pressure: ready stretches and stalls, both of random length.
   initial begin
      int on_len;
      int off_len;
      rsp_bus.ready = 1'b0;
      forever begin
         rsp_bus.ready <= 1'b1;
         on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
         repeat (on_len) @(posedge clock);
         off_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
         if (off_len > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (off_len) @(posedge clock);
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      cur_count = '0;
      req_bus.valid = 1'b0;
      req_bus.cmd = CMD_WRITE;
      req_bus.pixel_index = '0;
      req_bus.color = '0;
      no_gaps = 1'b0;
      items_sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Empty strand after reset: start bytes only; a write is dropped.
      send_item(CMD_SHOW, '0, '0);
      send_item(CMD_WRITE, '0, '1);

      // Full strand: store is black after reset, then fill every pixel.
      set_led_count(LED_COUNT_W'(MAX_LEDS_DEF));
      send_item(CMD_SHOW, '1, '1);
      for (int i = 0; i < MAX_LEDS_DEF; i++)
         send_item(CMD_WRITE, PIX_INDEX_W'(i), DIRECTED_COLORS[i]);
      send_item(CMD_WRITE, PIX_INDEX_W'(MAX_LEDS_DEF), 24'h0F0F0F);
      send_item(CMD_WRITE, '1, 24'h3C3C3C);
      send_item(CMD_SHOW, '0, '0);

      // Count beyond capacity clamps to capacity.
      set_led_count('1);
      send_item(CMD_WRITE, PIX_INDEX_W'(MAX_LEDS_DEF), 24'h111111);
      send_item(CMD_WRITE, PIX_INDEX_W'(MAX_LEDS_DEF - 1), 24'hC3C3C3);
      send_item(CMD_SHOW, '0, '0);

      set_led_count(LED_COUNT_W'(3));
      send_item(CMD_WRITE, PIX_INDEX_W'(3), 24'h222222);
      send_item(CMD_WRITE, PIX_INDEX_W'(2), 24'h5A5AA5);
      send_item(CMD_SHOW, '0, '0);

      set_led_count(LED_COUNT_W'(1));
      send_item(CMD_SHOW, '0, '0);

      run_random_phase(1'b1);
      while (items_sent < TARGET_ITEMS) run_random_phase(1'b0);

      wait_frames_done();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

/* sim.f */
rtl/lsfg_pkg.sv
rtl/lsfg_if.sv
rtl/lsfg_front.sv
rtl/lsfg_queue.sv
rtl/lsfg_back.sv
rtl/led_strip_frame_generator.sv
rtl/lsfg_checker.sv
test/lsfg_frame_checker.sv
test/testbench.sv
